@@ hdl/ibhq_pkg.sv @@
// Package with the constants, codes and helper type of the indexed binary heap queue.
package ibhq_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned PRI_W      = 31;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SETD  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADSLOT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOPERM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd5;

  localparam logic [1:0] REG_REMOVE_MODE   = 2'd0;
  localparam logic [1:0] REG_PRIORITY_MODE = 2'd1;
  localparam logic [1:0] REG_ACTIVE_SLOTS  = 2'd2;
  localparam logic [1:0] REG_DATA_ORDER    = 2'd3;

  localparam logic [COUNT_W-1:0] ACTIVE_SLOTS_RST = 11'd1024;

  typedef logic signed [PRI_W-1:0] pri_t;

endpackage

@@ hdl/indexed_binary_heap_queue_core.sv @@
// Indexed binary heap max-priority queue with numbered slots and an APB register port.
//
// One command is taken when start is high and busy is low; its result appears on the
// result ports, marked by done_o for exactly one cycle, and the receiver cannot stall it.
// All heap work runs through slot and heap memories with one read and one write port each
// and one shared priority compare unit under a sequencer. A push climbs the heap level by
// level. A pop or remove sinks the entry level by level, comparing both children or the
// only child where it has no sibling, and then climbs. An entry that sank is placed and
// the entry at its old position then climbs from there. A priority or data change on a
// queued slot runs a removal and then an insertion. An automatic-slot push scans the slots
// one by one for a free one, and a clear walks every slot. After reset a clearing pass
// zeroes the slot memories before the first command.
module indexed_binary_heap_queue_core #(
  parameter int unsigned SLOT_COUNT = ibhq_pkg::SLOT_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = ibhq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [ibhq_pkg::CMD_W-1:0]       cmd_i,
  input  logic [ibhq_pkg::SLOT_W-1:0]      slot_i,
  input  logic [ibhq_pkg::VALUE_W-1:0]     value_i,
  input  ibhq_pkg::pri_t                   priority_req_i,
  output logic                             done_o,
  output logic [ibhq_pkg::STATUS_W-1:0]    status_o,
  output logic [ibhq_pkg::SLOT_W-1:0]      out_slot_o,
  output logic [ibhq_pkg::VALUE_W-1:0]     out_value_o,
  output ibhq_pkg::pri_t                   out_priority_o,
  output logic                             slot_enabled_o,
  output logic [ibhq_pkg::SLOT_W-1:0]      heap_position_o,
  output logic                             is_empty_o,
  output logic [ibhq_pkg::COUNT_W-1:0]     entry_count_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ibhq_pkg::PADDR_W-1:0]     paddr,
  input  logic [ibhq_pkg::PDATA_W-1:0]     pwdata,
  output logic [ibhq_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import ibhq_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned UW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned DW = DATA_WIDTH;
  localparam logic [IW:0] LAST_IDX = (IW+1)'(SLOT_COUNT - 1);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_PUSH    = 5'd2;
  localparam logic [4:0] S_SCAN_RD = 5'd3;
  localparam logic [4:0] S_SCAN_CK = 5'd4;
  localparam logic [4:0] S_TOP     = 5'd5;
  localparam logic [4:0] S_TOP2    = 5'd6;
  localparam logic [4:0] S_REM     = 5'd7;
  localparam logic [4:0] S_SET     = 5'd8;
  localparam logic [4:0] S_READ    = 5'd9;
  localparam logic [4:0] S_CLR     = 5'd10;
  localparam logic [4:0] S_TAKE    = 5'd11;
  localparam logic [4:0] S_TAKE_S  = 5'd12;
  localparam logic [4:0] S_TAKE_D  = 5'd13;
  localparam logic [4:0] S_INS_RD  = 5'd14;
  localparam logic [4:0] S_INS_LD  = 5'd15;
  localparam logic [4:0] S_SD_CHK  = 5'd16;
  localparam logic [4:0] S_SD_C1S  = 5'd17;
  localparam logic [4:0] S_SD_C1D  = 5'd18;
  localparam logic [4:0] S_SD_C2D  = 5'd19;
  localparam logic [4:0] S_SD_CMP  = 5'd20;
  localparam logic [4:0] S_SU_CHK  = 5'd21;
  localparam logic [4:0] S_SU_S    = 5'd22;
  localparam logic [4:0] S_SU_D    = 5'd23;
  localparam logic [4:0] S_PLACE   = 5'd24;
  localparam logic [4:0] S_DONE    = 5'd25;
  localparam logic [4:0] S_SU2_PL  = 5'd26;
  localparam logic [4:0] S_SU2_S   = 5'd27;
  localparam logic [4:0] S_SU2_D   = 5'd28;

  // Configuration registers.
  logic               remove_mode_q, priority_mode_q, data_order_q;
  logic [COUNT_W-1:0] active_slots_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remove_mode_q   <= 1'b1;
      priority_mode_q <= 1'b1;
      active_slots_q  <= ACTIVE_SLOTS_RST;
      data_order_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_REMOVE_MODE:   remove_mode_q   <= pwdata[0];
        REG_PRIORITY_MODE: priority_mode_q <= pwdata[0];
        REG_ACTIVE_SLOTS:  active_slots_q  <= pwdata[COUNT_W-1:0];
        REG_DATA_ORDER:    data_order_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REMOVE_MODE:   prdata = PDATA_W'(remove_mode_q);
      REG_PRIORITY_MODE: prdata = PDATA_W'(priority_mode_q);
      REG_ACTIVE_SLOTS:  prdata = PDATA_W'(active_slots_q);
      REG_DATA_ORDER:    prdata = PDATA_W'(data_order_q);
      default:           prdata = '0;
    endcase
  end

  // Memories.
  logic [IW-1:0] heap_mem [SLOT_COUNT];
  logic [IW-1:0] pos_mem  [SLOT_COUNT];
  pri_t          pri_mem  [SLOT_COUNT];
  logic [DW-1:0] dat_mem  [SLOT_COUNT];
  logic          en_mem   [SLOT_COUNT];

  logic [IW-1:0] ha, sa;
  logic [IW-1:0] heap_rd, pos_rd;
  pri_t          pri_rd;
  logic [DW-1:0] dat_rd;
  logic          en_rd;

  logic          heap_we, pos_we, pri_we, dat_we, en_we;
  logic [IW-1:0] heap_wa, heap_wd, pos_wa, pos_wd, slot_wa;
  pri_t          pri_wd;
  logic [DW-1:0] dat_wd;
  logic          en_wd;

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd <= heap_mem[ha];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[sa];
  end

  always_ff @(posedge clk_i) begin
    if (pri_we) pri_mem[slot_wa] <= pri_wd;
    pri_rd <= pri_mem[sa];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) dat_mem[slot_wa] <= dat_wd;
    dat_rd <= dat_mem[sa];
  end

  always_ff @(posedge clk_i) begin
    if (en_we) en_mem[slot_wa] <= en_wd;
    en_rd <= en_mem[sa];
  end

  // Sequencer state.
  logic [4:0]          state_q, state_d;
  logic [IW:0]         cnt_q, cnt_d;
  logic [UW-1:0]       used_q, used_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [IW-1:0]       orig_q, orig_d;
  logic [IW-1:0]       e_slot_q, e_slot_d, c_slot_q, c_slot_d, c2_slot_q, c2_slot_d;
  logic [IW-1:0]       c_pos_q, c_pos_d;
  pri_t                e_pri_q, e_pri_d, c_pri_q, c_pri_d;
  logic [DW-1:0]       e_dat_q, e_dat_d, c_dat_q, c_dat_d;
  logic                has2_q, has2_d, ins_after_q, ins_after_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic [DW-1:0]       val_q, val_d;
  pri_t                preq_q, preq_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [IW-1:0]       oslot_q, oslot_d, hpos_q, hpos_d;
  logic [DW-1:0]       oval_q, oval_d;
  pri_t                opri_q, opri_d;
  logic                oen_q, oen_d;

  logic [UW-1:0] cap;
  logic          arr, accept, needs_slot;
  logic [IW:0]   ch;

  assign cap = (32'(active_slots_q) > SLOT_COUNT) ? UW'(SLOT_COUNT) : UW'(active_slots_q);
  assign arr = remove_mode_q | priority_mode_q;
  assign accept = start & ~busy;
  assign needs_slot = ((cmd_i == CMD_PUSH) && arr) || (cmd_i == CMD_REM) ||
                      (cmd_i == CMD_SETP) || (cmd_i == CMD_SETD) || (cmd_i == CMD_READ);
  assign ch = {pos_q, 1'b1};

  // Shared compare unit: true when operand a stands above operand b or ties with it.
  pri_t          cmp_a_pri, cmp_b_pri;
  logic [DW-1:0] cmp_a_dat, cmp_b_dat;
  logic          a_wins;

  always_comb begin
    if (cmp_a_pri != cmp_b_pri) begin
      a_wins = cmp_a_pri > cmp_b_pri;
    end else if (data_order_q) begin
      a_wins = cmp_a_dat >= cmp_b_dat;
    end else begin
      a_wins = 1'b1;
    end
  end

  always_comb begin
    if (state_q == S_SD_C2D) begin
      cmp_a_pri = c_pri_q;
      cmp_a_dat = c_dat_q;
    end else begin
      cmp_a_pri = e_pri_q;
      cmp_a_dat = e_dat_q;
    end
    if (state_q == S_SD_CMP) begin
      cmp_b_pri = c_pri_q;
      cmp_b_dat = c_dat_q;
    end else begin
      cmp_b_pri = pri_rd;
      cmp_b_dat = dat_rd;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    pos_d       = pos_q;
    orig_d      = orig_q;
    e_slot_d    = e_slot_q;
    e_pri_d     = e_pri_q;
    e_dat_d     = e_dat_q;
    c_slot_d    = c_slot_q;
    c2_slot_d   = c2_slot_q;
    c_pri_d     = c_pri_q;
    c_dat_d     = c_dat_q;
    c_pos_d     = c_pos_q;
    has2_d      = has2_q;
    ins_after_d = ins_after_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    val_d       = val_q;
    preq_d      = preq_q;
    st_d        = st_q;
    oslot_d     = oslot_q;
    oval_d      = oval_q;
    opri_d      = opri_q;
    oen_d       = oen_q;
    hpos_d      = hpos_q;
    ha          = '0;
    sa          = slot_q;
    heap_we     = 1'b0;
    heap_wa     = pos_q;
    heap_wd     = c_slot_q;
    pos_we      = 1'b0;
    pos_wa      = c_slot_q;
    pos_wd      = pos_q;
    pri_we      = 1'b0;
    dat_we      = 1'b0;
    en_we       = 1'b0;
    slot_wa     = slot_q;
    pri_wd      = preq_q;
    dat_wd      = val_q;
    en_wd       = 1'b0;

    unique case (state_q)
      S_INIT: begin
        slot_wa = cnt_q[IW-1:0];
        pri_we  = 1'b1;
        dat_we  = 1'b1;
        en_we   = 1'b1;
        pri_wd  = '0;
        dat_wd  = '0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        sa = IW'(slot_i);
        if (accept) begin
          cmd_d       = cmd_i;
          slot_d      = IW'(slot_i);
          val_d       = DW'(value_i);
          preq_d      = priority_req_i;
          st_d        = ST_OK;
          oslot_d     = '0;
          oval_d      = '0;
          opri_d      = '0;
          oen_d       = 1'b0;
          hpos_d      = '0;
          ins_after_d = 1'b0;
          cnt_d       = '0;
          if (needs_slot && (32'(slot_i) >= 32'(cap))) begin
            st_d    = ST_BADSLOT;
            state_d = S_DONE;
          end else if (((cmd_i == CMD_REM) && !remove_mode_q) ||
                       ((cmd_i == CMD_SETP) && !priority_mode_q) ||
                       (((cmd_i == CMD_SETD) || (cmd_i == CMD_READ)) && !arr)) begin
            st_d    = ST_NOPERM;
            state_d = S_DONE;
          end else begin
            unique case (cmd_i)
              CMD_PUSH: begin
                if (arr) begin
                  state_d = S_PUSH;
                end else if (32'(used_q) >= 32'(cap)) begin
                  st_d    = ST_FULL;
                  state_d = S_DONE;
                end else begin
                  state_d = S_SCAN_RD;
                end
              end
              CMD_POP, CMD_PEEK: begin
                if (used_q == '0) begin
                  st_d    = ST_EMPTY;
                  state_d = S_DONE;
                end else begin
                  state_d = S_TOP;
                end
              end
              CMD_REM:            state_d = S_REM;
              CMD_SETP, CMD_SETD: state_d = S_SET;
              CMD_READ:           state_d = S_READ;
              CMD_CLEAR:          state_d = S_CLR;
              default:            state_d = S_DONE;
            endcase
          end
        end
      end
      S_PUSH: begin
        if (en_rd) begin
          st_d    = ST_BUSY;
          state_d = S_DONE;
        end else if (32'(used_q) >= 32'(cap)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          dat_we  = 1'b1;
          en_we   = 1'b1;
          en_wd   = 1'b1;
          oslot_d = slot_q;
          state_d = S_INS_RD;
        end
      end
      S_SCAN_RD: begin
        sa      = cnt_q[IW-1:0];
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (!en_rd) begin
          slot_wa = cnt_q[IW-1:0];
          dat_we  = 1'b1;
          en_we   = 1'b1;
          en_wd   = 1'b1;
          slot_d  = cnt_q[IW-1:0];
          oslot_d = cnt_q[IW-1:0];
          state_d = S_INS_RD;
        end else if (32'(cnt_q) + 32'd1 >= 32'(cap)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_TOP: begin
        sa      = heap_rd;
        oslot_d = heap_rd;
        state_d = S_TOP2;
      end
      S_TOP2: begin
        oval_d = dat_rd;
        if (cmd_q == CMD_POP) begin
          slot_wa = oslot_q;
          en_we   = 1'b1;
          pos_d   = '0;
          state_d = S_TAKE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REM: begin
        if (en_rd) begin
          en_we   = 1'b1;
          pos_d   = pos_rd;
          state_d = S_TAKE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SET: begin
        if ((cmd_q == CMD_SETP) && en_rd && (pri_rd == preq_q)) begin
          state_d = S_DONE;
        end else begin
          pri_we = (cmd_q == CMD_SETP);
          dat_we = (cmd_q == CMD_SETD);
          if (en_rd) begin
            pos_d       = pos_rd;
            ins_after_d = 1'b1;
            state_d     = S_TAKE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        oslot_d = slot_q;
        oval_d  = dat_rd;
        opri_d  = pri_rd;
        oen_d   = en_rd;
        state_d = S_DONE;
      end
      S_CLR: begin
        slot_wa = cnt_q[IW-1:0];
        en_we   = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          used_d  = '0;
          state_d = S_DONE;
        end
      end
      S_TAKE: begin
        used_d = used_q - 1'b1;
        if (32'(pos_q) < 32'(used_q) - 32'd1) begin
          ha      = IW'(used_q - 1'b1);
          orig_d  = pos_q;
          state_d = S_TAKE_S;
        end else if (ins_after_q) begin
          ins_after_d = 1'b0;
          state_d     = S_INS_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TAKE_S: begin
        e_slot_d = heap_rd;
        sa       = heap_rd;
        state_d  = S_TAKE_D;
      end
      S_TAKE_D: begin
        e_pri_d = pri_rd;
        e_dat_d = dat_rd;
        state_d = S_SD_CHK;
      end
      S_INS_RD: begin
        sa      = slot_q;
        state_d = S_INS_LD;
      end
      S_INS_LD: begin
        e_slot_d = slot_q;
        e_pri_d  = pri_rd;
        e_dat_d  = dat_rd;
        pos_d    = IW'(used_q);
        used_d   = used_q + 1'b1;
        state_d  = S_SU_CHK;
      end
      S_SD_CHK: begin
        if (32'(ch) >= 32'(used_q)) begin
          state_d = (pos_q == orig_q) ? S_SU_CHK : S_SU2_PL;
        end else begin
          ha      = ch[IW-1:0];
          c_pos_d = ch[IW-1:0];
          has2_d  = (32'(ch) + 32'd1) < 32'(used_q);
          state_d = S_SD_C1S;
        end
      end
      S_SD_C1S: begin
        c_slot_d = heap_rd;
        sa       = heap_rd;
        ha       = c_pos_q + 1'b1;
        state_d  = S_SD_C1D;
      end
      S_SD_C1D: begin
        c_pri_d   = pri_rd;
        c_dat_d   = dat_rd;
        c2_slot_d = heap_rd;
        sa        = heap_rd;
        state_d   = has2_q ? S_SD_C2D : S_SD_CMP;
      end
      S_SD_C2D: begin
        if (!a_wins) begin
          c_slot_d = c2_slot_q;
          c_pri_d  = pri_rd;
          c_dat_d  = dat_rd;
          c_pos_d  = c_pos_q + 1'b1;
        end
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (a_wins) begin
          state_d = (pos_q == orig_q) ? S_SU_CHK : S_SU2_PL;
        end else begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
          pos_d   = c_pos_q;
          state_d = S_SD_CHK;
        end
      end
      S_SU2_PL: begin
        heap_we = 1'b1;
        heap_wd = e_slot_q;
        pos_we  = 1'b1;
        pos_wa  = e_slot_q;
        ha      = orig_q;
        pos_d   = orig_q;
        state_d = S_SU2_S;
      end
      S_SU2_S: begin
        e_slot_d = heap_rd;
        sa       = heap_rd;
        state_d  = S_SU2_D;
      end
      S_SU2_D: begin
        e_pri_d = pri_rd;
        e_dat_d = dat_rd;
        state_d = S_SU_CHK;
      end
      S_SU_CHK: begin
        if (pos_q == '0) begin
          state_d = S_PLACE;
        end else begin
          ha      = (pos_q - 1'b1) >> 1;
          c_pos_d = (pos_q - 1'b1) >> 1;
          state_d = S_SU_S;
        end
      end
      S_SU_S: begin
        c_slot_d = heap_rd;
        sa       = heap_rd;
        state_d  = S_SU_D;
      end
      S_SU_D: begin
        if (a_wins) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
          pos_d   = c_pos_q;
          state_d = S_SU_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        heap_wd = e_slot_q;
        pos_we  = 1'b1;
        pos_wa  = e_slot_q;
        if (ins_after_q) begin
          ins_after_d = 1'b0;
          state_d     = S_INS_RD;
        end else begin
          if ((cmd_q == CMD_PUSH) || (cmd_q == CMD_SETP) || (cmd_q == CMD_SETD)) begin
            hpos_d = pos_q;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      used_q      <= '0;
      ins_after_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      ins_after_q <= ins_after_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    orig_q    <= orig_d;
    e_slot_q  <= e_slot_d;
    e_pri_q   <= e_pri_d;
    e_dat_q   <= e_dat_d;
    c_slot_q  <= c_slot_d;
    c2_slot_q <= c2_slot_d;
    c_pri_q   <= c_pri_d;
    c_dat_q   <= c_dat_d;
    c_pos_q   <= c_pos_d;
    has2_q    <= has2_d;
    cmd_q     <= cmd_d;
    slot_q    <= slot_d;
    val_q     <= val_d;
    preq_q    <= preq_d;
    st_q      <= st_d;
    oslot_q   <= oslot_d;
    oval_q    <= oval_d;
    opri_q    <= opri_d;
    oen_q     <= oen_d;
    hpos_q    <= hpos_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = st_q;
  assign out_slot_o      = SLOT_W'(oslot_q);
  assign out_value_o     = VALUE_W'(oval_q);
  assign out_priority_o  = opri_q;
  assign slot_enabled_o  = oen_q;
  assign heap_position_o = SLOT_W'(hpos_q);
  assign is_empty_o      = (used_q == '0);
  assign entry_count_o   = COUNT_W'(used_q);

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (entry_count_o == '0))
    else $error("empty status with queued entries");

endmodule
